### src/sv39ptm_pkg.sv
package sv39ptm_pkg;

  localparam int unsigned PPN_W = 44;
  localparam int unsigned VPN_W = 27;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned CNT_W = 28;
  localparam int unsigned PTE_W = 64;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NO_TABLES = 2'd1;
  localparam logic [1:0] STATUS_FOREIGN   = 2'd2;

  // map request as it arrives on the input channel
  typedef struct packed {
    logic [38:0] virt_addr;
    logic [55:0] phys_addr;
    logic [38:0] size_bytes;
    logic [7:0]  permissions;
  } in_item_t;

  // one result per request
  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] pages_mapped;
  } out_item_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // request to the shared ppn adder
  typedef struct packed {
    alu_op_t          op;
    logic [PPN_W-1:0] a;
    logic [PPN_W-1:0] b;
  } alu_req_t;

endpackage

### src/sv39_page_table_mapper_unit.sv
// Sv39 page table mapper. A map request is taken when start is high and busy is
// low; one result transaction follows on out_strobe for a single cycle and
// cannot be held off, so the receiver must take it then. After reset the block
// stays busy while the table store is cleared one entry a cycle. A request
// costs, for every page, one step to start the walk, two read/evaluate steps
// and one leaf write; each new table page adds a clear of its 512 entries
// through the single store write port and one step to link it. Pace is set by
// the one write port and one read port of the table store and the shared
// 44-bit ppn adder. The table base register may only be written while busy is
// low.
module sv39_page_table_mapper_unit #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  sv39ptm_pkg::in_item_t         in_item,
  output logic                          out_strobe,
  output sv39ptm_pkg::out_item_t        out_item,
  input  logic                          cfg_we,
  input  logic [sv39ptm_pkg::PPN_W-1:0] cfg_wdata
);

  import sv39ptm_pkg::*;

  logic [PPN_W-1:0] base_ppn_r;

  // table base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ppn_r <= '0;
    end else if (cfg_we) begin
      base_ppn_r <= cfg_wdata;
    end
  end

  sv39ptm_walker #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .base_ppn   (base_ppn_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

### src/sv39ptm_ram.sv
module sv39ptm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/sv39ptm_alu.sv
module sv39ptm_alu (
  input  sv39ptm_pkg::alu_req_t           req,
  output logic [sv39ptm_pkg::PPN_W-1:0]   res
);

  import sv39ptm_pkg::*;

  // one 44-bit adder shared by pointer build, pointer rebase and leaf ppn step
  always_comb begin
    case (req.op)
      ALU_SUB: res = req.a - req.b;
      default: res = req.a + req.b;
    endcase
  end

endmodule

### src/sv39ptm_walker.sv
module sv39ptm_walker #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  sv39ptm_pkg::in_item_t         in_item,
  output logic                          busy,
  input  logic [sv39ptm_pkg::PPN_W-1:0] base_ppn,
  output logic                          out_strobe,
  output sv39ptm_pkg::out_item_t        out_item
);

  import sv39ptm_pkg::*;

  localparam int unsigned PW    = $clog2(TABLE_PAGES);
  localparam int unsigned CW    = $clog2(TABLE_PAGES + 1);
  localparam int unsigned DEPTH = TABLE_PAGES * (2 ** IDX_W);
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_NEXT,
    S_READ,
    S_EVAL,
    S_CLEAR,
    S_LINK,
    S_LEAF
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [1:0]       level_r, level_nxt;
  logic [PW-1:0]    table_r, table_nxt;
  logic [PW-1:0]    np_r, np_nxt;
  logic [CW-1:0]    free_r, free_nxt;
  logic [VPN_W-1:0] vpn_r, vpn_nxt;
  logic [PPN_W-1:0] ppn_r, ppn_nxt;
  logic [7:0]       perm_r, perm_nxt;
  logic [CNT_W-1:0] pages_r, pages_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;

  logic [IDX_W-1:0] vpn_idx;
  logic [AW-1:0]    slot_addr;
  logic             ram_we;
  logic [AW-1:0]    ram_wr_addr;
  logic [PTE_W-1:0] ram_wr_data;
  logic [PTE_W-1:0] ram_rd_data;
  alu_req_t         alu_req;
  logic [PPN_W-1:0] alu_res;
  logic [39:0]      size_round;

  sv39ptm_ram #(
    .WIDTH (PTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (slot_addr),
    .rd_data (ram_rd_data)
  );

  sv39ptm_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // table index for the current level
  always_comb begin
    case (level_r)
      2'd2:    vpn_idx = vpn_r[3*IDX_W-1:2*IDX_W];
      2'd1:    vpn_idx = vpn_r[2*IDX_W-1:IDX_W];
      default: vpn_idx = vpn_r[IDX_W-1:0];
    endcase
  end

  assign slot_addr  = {table_r, vpn_idx};
  assign size_round = {1'b0, in_item.size_bytes} + 40'd4095;

  // store write port
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = slot_addr;
    ram_wr_data = '0;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we      = 1'b1;
        ram_wr_addr = clr_addr_r;
      end
      S_LINK: begin
        ram_we      = 1'b1;
        ram_wr_data = {10'd0, alu_res, 9'd0, 1'b1};
      end
      S_LEAF: begin
        ram_we      = 1'b1;
        ram_wr_data = {10'd0, ppn_r, 2'd0, perm_r};
      end
      default: ram_we = 1'b0;
    endcase
  end

  // operands for the shared adder
  always_comb begin
    alu_req = '{op: ALU_ADD, a: base_ppn, b: '0};
    unique case (state_r)
      S_EVAL:  alu_req = '{op: ALU_SUB, a: ram_rd_data[10 +: PPN_W], b: base_ppn};
      S_LINK:  alu_req = '{op: ALU_ADD, a: base_ppn, b: PPN_W'(np_r)};
      S_LEAF:  alu_req = '{op: ALU_ADD, a: ppn_r, b: PPN_W'(1)};
      default: alu_req = '{op: ALU_ADD, a: base_ppn, b: '0};
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    level_nxt     = level_r;
    table_nxt     = table_r;
    np_nxt        = np_r;
    free_nxt      = free_r;
    vpn_nxt       = vpn_r;
    ppn_nxt       = ppn_r;
    perm_nxt      = perm_r;
    pages_nxt     = pages_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    unique case (state_r)
      S_INIT: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          vpn_nxt   = in_item.virt_addr[38:12];
          ppn_nxt   = in_item.phys_addr[55:12];
          perm_nxt  = in_item.permissions;
          pages_nxt = size_round[39:12];
          done_nxt  = '0;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (done_r == pages_r) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_DONE;
          state_nxt     = S_IDLE;
        end else begin
          level_nxt = 2'd2;
          table_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!ram_rd_data[0]) begin
          // invalid entry: allocate and clear a fresh table page, or report no tables when the store is full
          if (free_r == CW'(TABLE_PAGES)) begin
            out_valid_nxt = 1'b1;
            status_nxt    = STATUS_NO_TABLES;
            state_nxt     = S_IDLE;
          end else begin
            np_nxt       = free_r[PW-1:0];
            free_nxt     = free_r + CW'(1);
            clr_addr_nxt = {free_r[PW-1:0], {IDX_W{1'b0}}};
            state_nxt    = S_CLEAR;
          end
        end else if (alu_res >= PPN_W'(TABLE_PAGES)) begin
          // pointer lands outside the store
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_FOREIGN;
          state_nxt     = S_IDLE;
        end else begin
          table_nxt = alu_res[PW-1:0];
          level_nxt = level_r - 2'd1;
          state_nxt = (level_r == 2'd1) ? S_LEAF : S_READ;
        end
      end
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r[IDX_W-1:0] == {IDX_W{1'b1}}) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        table_nxt = np_r;
        level_nxt = level_r - 2'd1;
        state_nxt = (level_r == 2'd1) ? S_LEAF : S_READ;
      end
      S_LEAF: begin
        done_nxt  = done_r + CNT_W'(1);
        vpn_nxt   = vpn_r + VPN_W'(1);
        ppn_nxt   = alu_res;
        state_nxt = S_NEXT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_addr_r  <= '0;
      free_r      <= CW'(1);
      out_valid_r <= 1'b0;
      status_r    <= STATUS_DONE;
      done_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      done_r      <= done_nxt;
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    table_r <= table_nxt;
    np_r    <= np_nxt;
    vpn_r   <= vpn_nxt;
    ppn_r   <= ppn_nxt;
    perm_r  <= perm_nxt;
    pages_r <= pages_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_strobe            = out_valid_r;
  assign out_item.status       = status_r;
  assign out_item.pages_mapped = done_r;

endmodule
